FILE: rtl/mpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame detector package
// Shared constants, register reset values and configuration port sizing for
// the multi-pattern frame detector.
// ----------------------------------------------------------------------------
package mpfd_pkg;

  // Default geometry of the symbol stream and the frame.
  localparam int unsigned SYMBOL_BITS_DEF   = 8;
  localparam int unsigned PATTERN_LEN_DEF   = 5;
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Pattern registers: four of them, each 40 bits wide.
  localparam int unsigned NUM_PATTERNS = 4;
  localparam int unsigned REG_BITS     = 40;
  localparam int unsigned CODE_BITS    = 2;

  // Result position port width.
  localparam int unsigned MATCH_POS_BITS = 32;

  // APB port: 64-bit data, registers on 8-byte boundaries.
  localparam int unsigned CFG_DATA_BITS  = 64;
  localparam int unsigned CFG_ADDR_BITS  = 5;
  localparam int unsigned CFG_ADDR_LSB   = 3;

  // Reset values of the pattern registers, first symbol in the lowest byte.
  localparam logic [NUM_PATTERNS-1:0][REG_BITS-1:0] PATTERN_RESET = '{
    40'd21508588035,  // code 3: {3,2,3,2,5}
    40'd4311810305,   // code 2: {1,1,1,1,1}
    40'd21542142465,  // code 1: {1,2,3,4,5}
    40'd4328719365    // code 0: {5,4,3,2,1}
  };

endpackage

FILE: rtl/multi_pattern_frame_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-pattern frame detector
// Slides a window over a symbol stream and reports frames that equal one of
// four configured patterns, with the pattern code and the frame start index.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Beat contents
//  in        input      in_valid_i/in_ready_o  symbol_i, first_i
//  out       output     out_valid_o/out_ready_i match_code_o, match_position_o
//  cfg       input      APB psel/penable       paddr, pwdata, prdata (64 bit)
//
//  One symbol is taken per cycle unless a held result stalls the input; a
//  match reaches the output register in the cycle after the completing beat.
//  The window is a chain of PatternLen-1 cells; the frame compare runs in the
//  same cycle as the incoming symbol, set by one equality per pattern.
//  Reset clears the fill count, position and output valid; patterns take
//  their default values.
//  A stalled output holds the input only while its result register is full.
// ----------------------------------------------------------------------------
module multi_pattern_frame_detector_core #(
  parameter int unsigned SymbolBits   = mpfd_pkg::SYMBOL_BITS_DEF,
  parameter int unsigned PatternLen   = mpfd_pkg::PATTERN_LEN_DEF,
  parameter int unsigned PositionBits = mpfd_pkg::POSITION_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [SymbolBits-1:0]                symbol_i,
  input  logic                                 first_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mpfd_pkg::CODE_BITS-1:0]       match_code_o,
  output logic [mpfd_pkg::MATCH_POS_BITS-1:0]  match_position_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mpfd_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [mpfd_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [mpfd_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  localparam int unsigned NumCells  = PatternLen - 1;
  localparam int unsigned FillBits  = (PatternLen > 2) ? $clog2(PatternLen) : 1;
  localparam int unsigned FrameBits = PatternLen * SymbolBits;
  localparam int unsigned ExtBits   = (FrameBits > mpfd_pkg::REG_BITS) ?
                                      FrameBits : mpfd_pkg::REG_BITS;
  localparam int unsigned NP        = mpfd_pkg::NUM_PATTERNS;

  logic [NP-1:0][mpfd_pkg::REG_BITS-1:0] pattern;
  logic [NP-1:0][ExtBits-1:0]            pat_ext;

  logic [NumCells-1:0][SymbolBits-1:0]   win_sym;
  logic [NumCells-1:0][NP-1:0]           cell_hit;
  logic [NP-1:0]                         frame_hit;

  logic [FillBits-1:0]     fill_q, fill_d, fill_eff;
  logic [PositionBits-1:0] pos_q, pos_d, pos_eff, start_pos;
  logic                    accept, full, match;
  logic [mpfd_pkg::CODE_BITS-1:0] code;

  logic                                 out_valid_q;
  logic [mpfd_pkg::CODE_BITS-1:0]       code_q;
  logic [mpfd_pkg::MATCH_POS_BITS-1:0]  position_q;

  // Pattern register file.
  mpfd_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pattern_o (pattern)
  );

  // Patterns widened so that symbols above the register read as zero.
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      pat_ext[p] = ExtBits'(pattern[p]);
    end
  end

  // Window chain: the newest symbol enters the last cell, cell 0 is oldest.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    logic [NP-1:0][SymbolBits-1:0] pat_sym;
    logic [SymbolBits-1:0]         sym_in;

    always_comb begin
      for (int p = 0; p < NP; p++) begin
        pat_sym[p] = pat_ext[p][k*SymbolBits +: SymbolBits];
      end
    end

    if (k == NumCells - 1) begin : g_tail
      assign sym_in = symbol_i;
    end else begin : g_link
      assign sym_in = win_sym[k+1];
    end

    mpfd_cell #(
      .SymbolBits (SymbolBits)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (accept),
      .sym_i     (sym_in),
      .pat_sym_i (pat_sym),
      .sym_o     (win_sym[k]),
      .hit_o     (cell_hit[k])
    );
  end

  // Combine the cell hits with the compare of the incoming symbol.
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      frame_hit[p] = (symbol_i == pat_ext[p][NumCells*SymbolBits +: SymbolBits]);
      for (int k = 0; k < NumCells; k++) begin
        frame_hit[p] = frame_hit[p] & cell_hit[k][p];
      end
    end
  end

  // Lowest-numbered matching pattern wins.
  always_comb begin
    code = '0;
    for (int p = NP - 1; p >= 0; p--) begin
      if (frame_hit[p]) begin
        code = mpfd_pkg::CODE_BITS'(p);
      end
    end
  end

  // A new stream restarts the position and empties the window first.
  assign accept    = in_valid_i & in_ready_o;
  assign fill_eff  = first_i ? '0 : fill_q;
  assign pos_eff   = first_i ? '0 : pos_q;
  assign full      = (fill_eff == FillBits'(NumCells));
  assign match     = full & (|frame_hit);
  assign start_pos = pos_eff - PositionBits'(NumCells);
  assign pos_d     = pos_eff + PositionBits'(1);

  always_comb begin
    if (match) begin
      fill_d = '0;
    end else if (full) begin
      fill_d = fill_eff;
    end else begin
      fill_d = fill_eff + FillBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

  // Output register; a new beat may enter while the result is being taken.
  assign in_ready_o = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= match;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept & match) begin
      code_q     <= code;
      position_q <= mpfd_pkg::MATCH_POS_BITS'(
                      (PositionBits + mpfd_pkg::MATCH_POS_BITS)'(start_pos));
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_code_o     = code_q;
  assign match_position_o = position_q;

  // Checks on window fill, match results and position tracking.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillBits'(NumCells))
    else $error("fill count beyond window size");

  a_match_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && match |=> out_valid_o && (fill_q == '0))
    else $error("match did not produce a result and empty the window");

  a_fill_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full |=> fill_q == $past(fill_eff) + FillBits'(1))
    else $error("window did not grow on a partial frame");

  a_pos_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pos_q == $past(pos_eff) + PositionBits'(1))
    else $error("position did not advance by one");

endmodule

FILE: rtl/mpfd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame detector window cell
// Holds one symbol of the sliding window, takes its neighbor's symbol on each
// accepted beat and compares its symbol with the matching symbol of every
// pattern.
// ----------------------------------------------------------------------------
module mpfd_cell #(
  parameter int unsigned SymbolBits = mpfd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          shift_i,
  input  logic [SymbolBits-1:0]                         sym_i,
  input  logic [mpfd_pkg::NUM_PATTERNS-1:0][SymbolBits-1:0] pat_sym_i,
  output logic [SymbolBits-1:0]                         sym_o,
  output logic [mpfd_pkg::NUM_PATTERNS-1:0]             hit_o
);

  logic [SymbolBits-1:0] sym_q;

  // The symbol moves one place toward the oldest end on every beat.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sym_q <= sym_i;
    end
  end

  // Per-pattern equality of the held symbol.
  always_comb begin
    for (int p = 0; p < mpfd_pkg::NUM_PATTERNS; p++) begin
      hit_o[p] = (sym_q == pat_sym_i[p]);
    end
  end

  assign sym_o = sym_q;

endmodule

FILE: rtl/mpfd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame detector pattern registers
// APB-style register file holding the four 40-bit pattern registers.
// ----------------------------------------------------------------------------
module mpfd_regs (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [mpfd_pkg::CFG_ADDR_BITS-1:0]          paddr,
  input  logic [mpfd_pkg::CFG_DATA_BITS-1:0]          pwdata,
  output logic [mpfd_pkg::CFG_DATA_BITS-1:0]          prdata,
  output logic                                        pready,
  output logic [mpfd_pkg::NUM_PATTERNS-1:0][mpfd_pkg::REG_BITS-1:0] pattern_o
);

  localparam int unsigned IdxBits = mpfd_pkg::CFG_ADDR_BITS - mpfd_pkg::CFG_ADDR_LSB;

  logic [mpfd_pkg::NUM_PATTERNS-1:0][mpfd_pkg::REG_BITS-1:0] pattern_q;
  logic [IdxBits-1:0] reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[mpfd_pkg::CFG_ADDR_BITS-1:mpfd_pkg::CFG_ADDR_LSB];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register write in the access phase; data is cut to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= mpfd_pkg::PATTERN_RESET;
    end else if (wr_en) begin
      for (int p = 0; p < mpfd_pkg::NUM_PATTERNS; p++) begin
        if (reg_idx == IdxBits'(p)) begin
          pattern_q[p] <= pwdata[mpfd_pkg::REG_BITS-1:0];
        end
      end
    end
  end

  // Read data is the addressed register, zero extended.
  assign prdata    = mpfd_pkg::CFG_DATA_BITS'(pattern_q[reg_idx]);
  assign pattern_o = pattern_q;

endmodule

FILE: tb/mpfd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame detector checker
// Watches the symbol, match and APB channels of the frame detector. It keeps
// its own copy of the pattern registers and of the sliding window, predicts
// the match that each accepted symbol beat causes, and compares every
// accepted match beat with the oldest prediction. Register reads are checked
// against the shadow copy.
// ----------------------------------------------------------------------------
module mpfd_frame_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [mpfd_pkg::SYMBOL_BITS_DEF-1:0] symbol_i,
  input  logic                                first_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [mpfd_pkg::CODE_BITS-1:0]      match_code_i,
  input  logic [mpfd_pkg::MATCH_POS_BITS-1:0] match_position_i,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [mpfd_pkg::CFG_ADDR_BITS-1:0]  paddr_i,
  input  logic [mpfd_pkg::CFG_DATA_BITS-1:0]  pwdata_i,
  input  logic [mpfd_pkg::CFG_DATA_BITS-1:0]  prdata_i,
  input  logic                                pready_i,
  input  logic                                drain_check_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o,
  output int unsigned                         symbols_o,
  output int unsigned                         matches_o
);

  localparam int unsigned SYM_W     = mpfd_pkg::SYMBOL_BITS_DEF;
  localparam int unsigned FRAME_LEN = mpfd_pkg::PATTERN_LEN_DEF;
  localparam int unsigned POS_W     = mpfd_pkg::MATCH_POS_BITS;
  localparam int unsigned CODE_W    = mpfd_pkg::CODE_BITS;
  localparam int unsigned NUM_PAT   = mpfd_pkg::NUM_PATTERNS;
  localparam int unsigned REG_W     = mpfd_pkg::REG_BITS;
  localparam int unsigned DATA_W    = mpfd_pkg::CFG_DATA_BITS;
  localparam int unsigned FRAME_W   = FRAME_LEN * SYM_W;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  position;
  } frame_match_t;

  // Predicted matches, oldest first.
  frame_match_t expected_matches[$];

  // Shadow state of the detector.
  logic [SYM_W-1:0] window_q [FRAME_LEN-1];
  int unsigned      fill_q;
  logic [POS_W-1:0] next_pos_q;
  logic [REG_W-1:0] pattern_q [NUM_PAT];
  logic             drained_q;

  int unsigned       reg_idx;
  logic [DATA_W-1:0] read_want;
  frame_match_t      got_match;
  frame_match_t      want_match;

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  // Advances the shadow window by one symbol and queues the match it causes.
  task automatic advance_frame(input logic [SYM_W-1:0] sym, input logic frst);
    logic [FRAME_W-1:0] frame;
    logic [POS_W-1:0]   here;
    int                 code;
    code = -1;
    // A new stream restarts the index and drops any partial frame.
    if (frst) begin
      next_pos_q = '0;
      fill_q     = 0;
      for (int k = 0; k < FRAME_LEN - 1; k++) window_q[k] = '0;
    end
    here       = next_pos_q;
    next_pos_q = next_pos_q + 1'b1;
    if (fill_q < FRAME_LEN - 1) begin
      window_q[fill_q] = sym;
      fill_q++;
      return;
    end
    for (int k = 0; k < FRAME_LEN - 1; k++) frame[k*SYM_W +: SYM_W] = window_q[k];
    frame[(FRAME_LEN-1)*SYM_W +: SYM_W] = sym;
    // The lowest-numbered matching pattern wins.
    for (int p = 0; p < NUM_PAT; p++) begin
      if (code < 0 && frame == pattern_q[p][FRAME_W-1:0]) code = p;
    end
    if (code >= 0) begin
      expected_matches.push_back('{code: CODE_W'(code),
                                   position: here - POS_W'(FRAME_LEN - 1)});
      fill_q = 0;
      for (int k = 0; k < FRAME_LEN - 1; k++) window_q[k] = '0;
    end else begin
      for (int k = 0; k < FRAME_LEN - 2; k++) window_q[k] = window_q[k+1];
      window_q[FRAME_LEN-2] = sym;
    end
  endtask

  // Sample all channels at the clock edge and update the shadow state.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PAT; p++) pattern_q[p] = mpfd_pkg::PATTERN_RESET[p];
      for (int k = 0; k < FRAME_LEN - 1; k++) window_q[k] = '0;
      fill_q       = 0;
      next_pos_q   = '0;
      drained_q    = 1'b0;
      fail_count_o = 0;
      symbols_o    = 0;
      matches_o    = 0;
      expected_matches.delete();
    end else begin
      // Register access phase.
      if (psel_i && penable_i && pready_i) begin
        reg_idx = paddr_i >> mpfd_pkg::CFG_ADDR_LSB;
        if (pwrite_i) begin
          if (reg_idx < NUM_PAT) pattern_q[reg_idx] = pwdata_i[REG_W-1:0];
        end else begin
          read_want = '0;
          if (reg_idx < NUM_PAT) read_want[REG_W-1:0] = pattern_q[reg_idx];
          if (prdata_i !== read_want)
            report_mismatch($sformatf("register %0d read 0x%0h, expected 0x%0h",
                                      reg_idx, prdata_i, read_want));
        end
      end
      // Symbol beat.
      if (in_valid_i && in_ready_i) begin
        symbols_o++;
        advance_frame(symbol_i, first_i);
      end
      // Match beat.
      if (out_valid_i && out_ready_i) begin
        got_match = '{code: match_code_i, position: match_position_i};
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected match code %0d position %0d",
                                    match_code_i, match_position_i));
        end else begin
          want_match = expected_matches.pop_front();
          matches_o++;
          if (got_match.code !== want_match.code)
            report_mismatch($sformatf("match code %0d, expected %0d (position %0d)",
                                      got_match.code, want_match.code,
                                      want_match.position));
          if (got_match.position !== want_match.position)
            report_mismatch($sformatf("match position %0d, expected %0d",
                                      got_match.position, want_match.position));
        end
      end
      // End of run: nothing may remain predicted.
      if (drain_check_i && !drained_q) begin
        drained_q = 1'b1;
        if (expected_matches.size() != 0)
          report_mismatch($sformatf("%0d predicted matches never arrived",
                                    expected_matches.size()));
      end
      pending_o = expected_matches.size();
    end
  end

endmodule

FILE: tb/multi_pattern_frame_detector_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame detector testbench
// Drives symbol streams into the frame detector through several pattern
// settings and idle modes, with a directed opening, random well-formed and
// broken frames, and one long receiver hold-off. A checker beside the block
// predicts and compares every match; this module gives the verdict.
// ----------------------------------------------------------------------------
module multi_pattern_frame_detector_core_tb;

  localparam int unsigned SYM_W       = mpfd_pkg::SYMBOL_BITS_DEF;
  localparam int unsigned FRAME_LEN   = mpfd_pkg::PATTERN_LEN_DEF;
  localparam int unsigned REG_W       = mpfd_pkg::REG_BITS;
  localparam int unsigned DATA_W      = mpfd_pkg::CFG_DATA_BITS;
  localparam int unsigned ADDR_W      = mpfd_pkg::CFG_ADDR_BITS;
  localparam int unsigned NUM_PAT     = mpfd_pkg::NUM_PATTERNS;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Register indexes.
  localparam int unsigned REG_PATTERN_ZERO  = 0;
  localparam int unsigned REG_PATTERN_ONE   = 1;
  localparam int unsigned REG_PATTERN_TWO   = 2;
  localparam int unsigned REG_PATTERN_THREE = 3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [SYM_W-1:0] symbol_i = '0;
  logic first_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [mpfd_pkg::CODE_BITS-1:0] match_code_o;
  logic [mpfd_pkg::MATCH_POS_BITS-1:0] match_position_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic drain_check = 1'b0;
  logic hold_req = 1'b0;
  idle_mode_e idle_mode = IDLE_NONE;
  int unsigned hold_count = 0;
  int unsigned cycle_count = 0;
  int unsigned symbols_sent = 0;
  int unsigned settings_done = 0;
  logic [REG_W-1:0] pattern_cfg [NUM_PAT];

  int unsigned fail_count;
  int unsigned pending;
  int unsigned symbols_seen;
  int unsigned matches_seen;

  multi_pattern_frame_detector_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .symbol_i         (symbol_i),
    .first_i          (first_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_code_o     (match_code_o),
    .match_position_o (match_position_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  mpfd_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .symbol_i         (symbol_i),
    .first_i          (first_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .match_code_i     (match_code_o),
    .match_position_i (match_position_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .prdata_i         (prdata),
    .pready_i         (pready),
    .drain_check_i    (drain_check),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .symbols_o        (symbols_seen),
    .matches_o        (matches_seen)
  );

  // Clock.
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d matches still pending", cycle_count, pending);
      $display("multi_pattern_frame_detector_core verification failed");
      $finish;
    end
  end

  function automatic int unsigned sender_idle_pct(input idle_mode_e m);
    case (m)
      IDLE_SENDER: return 60;
      IDLE_BOTH:   return 19;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct(input idle_mode_e m);
    case (m)
      IDLE_RECEIVER: return 60;
      IDLE_BOTH:     return 19;
      default:       return 0;
    endcase
  endfunction

  // Match receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req && hold_count < LONG_HOLD) begin
      hold_count  <= hold_count + 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct(idle_mode));
    end
  end

  // Offers one symbol beat and returns at the edge that accepts it.
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic frst);
    while ($urandom_range(0, 99) < sender_idle_pct(idle_mode)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    first_i    <= frst;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    symbols_sent++;
  endtask

  // One APB transfer: setup phase, access phase, then an idle phase.
  task automatic apb_access(input logic wr, input int unsigned idx,
                            input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx << mpfd_pkg::CFG_ADDR_LSB);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes all four patterns, with junk above bit 39, and reads them back.
  task automatic load_patterns(input logic [REG_W-1:0] p0, input logic [REG_W-1:0] p1,
                               input logic [REG_W-1:0] p2, input logic [REG_W-1:0] p3);
    pattern_cfg[REG_PATTERN_ZERO]  = p0;
    pattern_cfg[REG_PATTERN_ONE]   = p1;
    pattern_cfg[REG_PATTERN_TWO]   = p2;
    pattern_cfg[REG_PATTERN_THREE] = p3;
    for (int unsigned r = REG_PATTERN_ZERO; r <= REG_PATTERN_THREE; r++)
      apb_access(1'b1, r, {24'($urandom), pattern_cfg[r]});
    for (int unsigned r = REG_PATTERN_ZERO; r <= REG_PATTERN_THREE; r++)
      apb_access(1'b0, r, '0);
    settings_done++;
  endtask

  function automatic logic [REG_W-1:0] random_pattern(input int unsigned max_sym);
    logic [REG_W-1:0] v;
    v = '0;
    for (int k = 0; k < FRAME_LEN; k++) v[k*SYM_W +: SYM_W] = SYM_W'($urandom_range(0, max_sym));
    return v;
  endfunction

  // Sends a short burst: mostly a full configured frame, sometimes a broken
  // or truncated one, sometimes a single noise symbol.
  task automatic send_burst();
    int unsigned roll;
    int unsigned pat;
    int unsigned len;
    int unsigned bad;
    logic        restart;
    logic [SYM_W-1:0] sym;
    roll    = $urandom_range(0, 99);
    pat     = $urandom_range(0, NUM_PAT - 1);
    restart = ($urandom_range(0, 99) < 8);
    if (roll < 60) begin
      repeat ($urandom_range(0, 2)) begin
        send_symbol(SYM_W'($urandom), restart);
        restart = 1'b0;
      end
      for (int k = 0; k < FRAME_LEN; k++) begin
        send_symbol(pattern_cfg[pat][k*SYM_W +: SYM_W], restart && k == 0);
      end
    end else if (roll < 80) begin
      len = $urandom_range(1, FRAME_LEN);
      bad = $urandom_range(0, FRAME_LEN - 1);
      for (int k = 0; k < len; k++) begin
        sym = pattern_cfg[pat][k*SYM_W +: SYM_W];
        if (len == FRAME_LEN && k == bad) sym = sym ^ SYM_W'($urandom_range(1, 255));
        send_symbol(sym, restart && k == 0);
      end
    end else begin
      send_symbol(SYM_W'($urandom), ($urandom_range(0, 99) < 10));
    end
  endtask

  // Drops valid, waits for every predicted match, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One random phase under the given idle mode.
  task automatic run_phase(input idle_mode_e mode, input int unsigned n_items,
                           input logic long_hold);
    int unsigned target;
    idle_mode <= mode;
    if (long_hold) hold_req <= 1'b1;
    @(posedge clk_i);
    target = symbols_sent + n_items;
    while (symbols_sent < target) send_burst();
    wait_idle();
  endtask

  // Stimulus and verdict.
  initial begin
    logic [REG_W-1:0] dup;
    for (int p = 0; p < NUM_PAT; p++) pattern_cfg[p] = mpfd_pkg::PATTERN_RESET[p];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values read back.
    for (int unsigned r = REG_PATTERN_ZERO; r <= REG_PATTERN_THREE; r++)
      apb_access(1'b0, r, '0);
    settings_done++;

    // Directed: slide then code 0, code 1, slide then code 2, then a restart
    // that drops a partial frame before code 3.
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'd5, 1'b0); send_symbol(8'd4, 1'b0); send_symbol(8'd3, 1'b0);
    send_symbol(8'd2, 1'b0); send_symbol(8'd1, 1'b0);
    send_symbol(8'd1, 1'b0); send_symbol(8'd2, 1'b0); send_symbol(8'd3, 1'b0);
    send_symbol(8'd4, 1'b0); send_symbol(8'd5, 1'b0);
    send_symbol(8'h00, 1'b0);
    for (int k = 0; k < FRAME_LEN; k++) send_symbol(8'd1, 1'b0);
    send_symbol(8'hFF, 1'b0); send_symbol(8'd3, 1'b0);
    send_symbol(8'd3, 1'b1); send_symbol(8'd2, 1'b0); send_symbol(8'd3, 1'b0);
    send_symbol(8'd2, 1'b0); send_symbol(8'd5, 1'b0);
    wait_idle();

    // Extreme patterns: all-zero and all-ones frames.
    load_patterns('0, {REG_W{1'b1}}, random_pattern(255), random_pattern(255));
    run_phase(IDLE_NONE, 110, 1'b0);

    load_patterns(random_pattern(255), random_pattern(255),
                  random_pattern(255), random_pattern(255));
    run_phase(IDLE_SENDER, 110, 1'b0);

    // Duplicate patterns so that priority decides the code.
    dup = random_pattern(3);
    load_patterns(random_pattern(3), dup, dup, dup);
    run_phase(IDLE_RECEIVER, 110, 1'b0);

    load_patterns(random_pattern(3), random_pattern(3),
                  random_pattern(3), random_pattern(3));
    run_phase(IDLE_BOTH, 110, 1'b0);

    // Back to the reset patterns while the receiver holds off for a long time.
    load_patterns(mpfd_pkg::PATTERN_RESET[REG_PATTERN_ZERO],
                  mpfd_pkg::PATTERN_RESET[REG_PATTERN_ONE],
                  mpfd_pkg::PATTERN_RESET[REG_PATTERN_TWO],
                  mpfd_pkg::PATTERN_RESET[REG_PATTERN_THREE]);
    run_phase(IDLE_NONE, 100, 1'b1);

    load_patterns(40'hFF00FF00FF, 40'h00FF00FF00, random_pattern(255), random_pattern(3));
    run_phase(IDLE_BOTH, 110, 1'b0);

    // Final drain check.
    drain_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    $display("Summary: %0d symbol beats over %0d pattern settings, %0d matches checked",
             symbols_seen, settings_done, matches_seen);
    $display("Idle modes none, sender, receiver and both, with one %0d-cycle hold-off",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("multi_pattern_frame_detector_core verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("multi_pattern_frame_detector_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mpfd_pkg.sv
rtl/mpfd_cell.sv
rtl/mpfd_regs.sv
rtl/multi_pattern_frame_detector_core.sv
tb/mpfd_frame_checker.sv
tb/multi_pattern_frame_detector_core_tb.sv
